// ----- src/block_cache_lookup_lru_defines.svh -----
`ifndef BLOCK_CACHE_LOOKUP_LRU_DEFINES_SVH
`define BLOCK_CACHE_LOOKUP_LRU_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BCLRU_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bclru check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BCLRU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bclru check failed");

`endif

// ----- src/bclru_pkg.sv -----
package bclru_pkg;

  localparam int unsigned PC_W        = 64;
  localparam int unsigned STAMP_W     = 64;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned ENTRY_W     = CNT_W + STAMP_W + PC_W;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_FIELD_W = SLOT_W + 1 + 1 + PC_W + CNT_W + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    SRC_RECENT,
    SRC_PROBE_HIT,
    SRC_PROBE_EMPTY,
    SRC_SCAN
  } src_e;

  typedef enum logic [1:0] {
    RD_RECENT,
    RD_PROBE,
    RD_FIRST,
    RD_SCAN
  } rd_sel_e;

  typedef struct packed {
    logic    clear_wr;
    logic    accept;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    ld_home;
    logic    probe_adv;
    logic    scan_start;
    logic    scan_eval;
    logic    commit;
    logic    bad;
    src_e    src;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic pc_zero;
    logic recent_valid;
    logic mod_done;
    logic tag_empty;
    logic tag_match;
    logic probe_last;
    logic scan_stop;
    logic out_free;
  } sts_t;

endpackage

// ----- src/block_cache_lookup_lru.sv -----
// Steps: accept, recent-slot check, home index (bit mask for a power of two table, serial
//   nibble-wise reduction otherwise), probe of up to PROBE_LIMIT entries, LRU scan, commit.
// A recent-slot hit goes straight to commit; the scan runs only when every probe misses.
// Throughput: one lookup at a time; the one read port of the table RAM sets the scan rate.
// Reset: asynchronous, active low; then a clearing pass over every table entry
//   with s_axis_tready low.
module block_cache_lookup_lru
  import bclru_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned PROBE_LIMIT   = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // lookup_pc[63:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // slot_index[5:0], hit[6], evicted[7], victim_pc[71:8], use_count[103:72],
  // bad_pc[104], zero fill[111:105]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;

  bclru_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bclru_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PROBE_LIMIT  (PROBE_LIMIT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ----- src/bclru_ram.sv -----
module bclru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bclru_mod.sv -----
module bclru_mod
  import bclru_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [PC_W-1:0]                  pc_i,
  output logic                             done_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] rem_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_mask
    logic [IDX_W-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q <= '0;
      end else if (start_i) begin
        rem_q <= pc_i[IDX_W-1:0];
      end
    end

    assign rem_o  = rem_q;
    assign done_o = 1'b1;
  end else begin : g_serial
    localparam int unsigned DIG_W    = 4;
    localparam int unsigned TRIAL_W  = IDX_W + DIG_W;
    localparam int unsigned DIGITS   = PC_W / DIG_W;
    localparam int unsigned CNT_BITS = $clog2(DIGITS);
    localparam logic [CNT_BITS-1:0] LAST_DIGIT = CNT_BITS'(DIGITS - 1);

    logic [IDX_W-1:0]    rem_q;
    logic [PC_W-1:0]     sh_q;
    logic [CNT_BITS-1:0] cnt_q;
    logic                busy_q;
    logic [TRIAL_W-1:0]  trial;
    logic [IDX_W-1:0]    rem_next;

    assign trial = {rem_q, sh_q[PC_W-1 -: DIG_W]};

    // Subtract the largest multiple of the table size that fits.
    always_comb begin
      rem_next = IDX_W'(trial);
      for (int unsigned k = 1; k < (1 << DIG_W); k++) begin
        if (trial >= TRIAL_W'(k * TABLE_ENTRIES)) begin
          rem_next = IDX_W'(trial - TRIAL_W'(k * TABLE_ENTRIES));
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
        if (cnt_q == LAST_DIGIT) begin
          busy_q <= 1'b0;
        end
      end
    end

    // Shift in one pc nibble a cycle, reduce by one compare and subtract.
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= '0;
        sh_q  <= pc_i;
      end else if (busy_q) begin
        sh_q  <= {sh_q[PC_W-DIG_W-1:0], {DIG_W{1'b0}}};
        rem_q <= rem_next;
      end
    end

    assign rem_o  = rem_q;
    assign done_o = !busy_q;
  end

endmodule

// ----- src/bclru_ctrl.sv -----
module bclru_ctrl
  import bclru_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_RECENT,
    ST_CMP_RECENT,
    ST_MOD_WAIT,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_SCAN_RD0,
    ST_SCAN,
    ST_COMMIT,
    ST_BAD
  } state_e;

  state_e state_q;
  src_e   src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      src_q   <= SRC_RECENT;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            priority if (sts_i.pc_zero) begin
              state_q <= ST_BAD;
            end else if (sts_i.recent_valid) begin
              state_q <= ST_RD_RECENT;
            end else begin
              state_q <= ST_MOD_WAIT;
            end
          end
        end
        ST_RD_RECENT: state_q <= ST_CMP_RECENT;
        ST_CMP_RECENT: begin
          if (sts_i.tag_match) begin
            src_q   <= SRC_RECENT;
            state_q <= ST_COMMIT;
          end else begin
            state_q <= ST_MOD_WAIT;
          end
        end
        ST_MOD_WAIT: begin
          if (sts_i.mod_done) begin
            state_q <= ST_PROBE_RD;
          end
        end
        ST_PROBE_RD: state_q <= ST_PROBE_CMP;
        ST_PROBE_CMP: begin
          priority if (sts_i.tag_empty) begin
            src_q   <= SRC_PROBE_EMPTY;
            state_q <= ST_COMMIT;
          end else if (sts_i.tag_match) begin
            src_q   <= SRC_PROBE_HIT;
            state_q <= ST_COMMIT;
          end else if (sts_i.probe_last) begin
            state_q <= ST_SCAN_RD0;
          end else begin
            state_q <= ST_PROBE_RD;
          end
        end
        ST_SCAN_RD0: state_q <= ST_SCAN;
        ST_SCAN: begin
          if (sts_i.scan_stop) begin
            src_q   <= SRC_SCAN;
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT, ST_BAD: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.src    = src_q;
    cmd_o.rd_sel = RD_RECENT;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_RD_RECENT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_RECENT;
      end
      ST_MOD_WAIT: cmd_o.ld_home = sts_i.mod_done;
      ST_PROBE_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PROBE;
      end
      ST_PROBE_CMP: begin
        cmd_o.probe_adv = !sts_i.tag_empty && !sts_i.tag_match && !sts_i.probe_last;
      end
      ST_SCAN_RD0: begin
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_sel     = RD_FIRST;
        cmd_o.scan_start = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = RD_SCAN;
        cmd_o.scan_eval = 1'b1;
      end
      ST_COMMIT: cmd_o.commit = sts_i.out_free;
      ST_BAD: cmd_o.bad = sts_i.out_free;
      default: cmd_o.accept = 1'b0;
    endcase
  end

endmodule

// ----- src/bclru_dp.sv -----
module bclru_dp
  import bclru_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned PROBE_LIMIT   = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned STEP_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int unsigned WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROBE_LIMIT - 1);

  logic [PC_W-1:0]        pc_q;
  logic [IDX_W-1:0]       clr_ptr_q;
  logic [IDX_W-1:0]       recent_q;
  logic                   recent_vld_q;
  logic [STAMP_W-1:0]     stamp_ctr_q;
  logic [IDX_W-1:0]       idx_q;
  logic [STEP_W-1:0]      step_q;
  logic [IDX_W-1:0]       ev_q;
  logic [IDX_W-1:0]       best_q;
  logic [STAMP_W-1:0]     least_q;
  logic [PC_W-1:0]        best_tag_q;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic                   home_done;
  logic [IDX_W-1:0]       home_idx;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [PC_W-1:0]        rd_tag;
  logic [STAMP_W-1:0]     rd_stamp;
  logic [CNT_W-1:0]       rd_cnt;
  logic [IDX_W-1:0]       slot_sel;
  logic                   hit_sel;
  logic [CNT_W-1:0]       base_cnt;
  logic [CNT_W-1:0]       new_cnt;
  logic [STAMP_W-1:0]     stamp_next;
  logic [PC_W-1:0]        victim;
  logic [WIDE_W-1:0]      slot_wide;
  logic                   scan_at_end;

  assign rd_tag   = ram_rdata[PC_W-1:0];
  assign rd_stamp = ram_rdata[PC_W+STAMP_W-1:PC_W];
  assign rd_cnt   = ram_rdata[ENTRY_W-1:PC_W+STAMP_W];

  bclru_mod #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.accept),
    .pc_i   (in_data_i[PC_W-1:0]),
    .done_o (home_done),
    .rem_o  (home_idx)
  );

  bclru_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign scan_at_end = (ev_q == LAST_IDX);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_RECENT: ram_raddr = recent_q;
      RD_PROBE:  ram_raddr = idx_q;
      RD_FIRST:  ram_raddr = '0;
      RD_SCAN:   ram_raddr = ev_q + IDX_W'(1);
      default:   ram_raddr = '0;
    endcase
  end

  assign ram_re = cmd_i.rd_en && !(cmd_i.rd_sel == RD_SCAN && scan_at_end);

  always_comb begin
    unique case (cmd_i.src)
      SRC_RECENT:      slot_sel = recent_q;
      SRC_PROBE_HIT:   slot_sel = idx_q;
      SRC_PROBE_EMPTY: slot_sel = idx_q;
      SRC_SCAN:        slot_sel = best_q;
      default:         slot_sel = best_q;
    endcase
  end

  assign hit_sel    = (cmd_i.src == SRC_RECENT) || (cmd_i.src == SRC_PROBE_HIT);
  assign base_cnt   = hit_sel ? rd_cnt : '0;
  assign new_cnt    = (base_cnt == CNT_MAX) ? base_cnt : base_cnt + CNT_W'(1);
  assign stamp_next = stamp_ctr_q + STAMP_W'(1);
  assign victim     = (cmd_i.src == SRC_SCAN) ? best_tag_q : '0;
  assign slot_wide  = WIDE_W'(slot_sel);

  assign ram_we    = cmd_i.clear_wr || cmd_i.commit;
  assign ram_waddr = cmd_i.clear_wr ? clr_ptr_q : slot_sel;
  assign ram_wdata = cmd_i.clear_wr ? '0 : {new_cnt, stamp_next, pc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q    <= '0;
      recent_q     <= '0;
      recent_vld_q <= 1'b0;
      stamp_ctr_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_wr) begin
        clr_ptr_q <= clr_ptr_q + IDX_W'(1);
      end
      if (cmd_i.commit) begin
        recent_q     <= slot_sel;
        recent_vld_q <= 1'b1;
        stamp_ctr_q  <= stamp_next;
      end
      if (cmd_i.commit || cmd_i.bad) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pc_q <= in_data_i[PC_W-1:0];
    end
    if (cmd_i.ld_home) begin
      idx_q  <= home_idx;
      step_q <= '0;
    end else if (cmd_i.probe_adv) begin
      idx_q  <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
      step_q <= step_q + STEP_W'(1);
    end
    if (cmd_i.scan_start) begin
      ev_q <= '0;
    end else if (cmd_i.scan_eval) begin
      ev_q <= ev_q + IDX_W'(1);
      priority if (ev_q == '0) begin
        best_q     <= '0;
        least_q    <= rd_stamp;
        best_tag_q <= rd_tag;
      end else if (rd_tag == '0) begin
        best_q     <= ev_q;
        best_tag_q <= '0;
      end else if (rd_stamp < least_q) begin
        best_q     <= ev_q;
        least_q    <= rd_stamp;
        best_tag_q <= rd_tag;
      end
    end
    if (cmd_i.commit) begin
      out_data_q <= OUT_TDATA_W'({1'b0, new_cnt, victim, (victim != '0), hit_sel,
                                  slot_wide[SLOT_W-1:0]});
    end else if (cmd_i.bad) begin
      out_data_q <= OUT_TDATA_W'({1'b1, {(OUT_FIELD_W - 1){1'b0}}});
    end
  end

  assign sts_o.clear_last   = (clr_ptr_q == LAST_IDX);
  assign sts_o.pc_zero      = (in_data_i[PC_W-1:0] == '0);
  assign sts_o.recent_valid = recent_vld_q;
  assign sts_o.mod_done     = home_done;
  assign sts_o.tag_empty    = (rd_tag == '0);
  assign sts_o.tag_match    = (rd_tag == pc_q);
  assign sts_o.probe_last   = (step_q == LAST_STEP);
  assign sts_o.scan_stop    = ((ev_q != '0) && (rd_tag == '0)) || scan_at_end;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- src/bclru_chk.sv -----
`include "block_cache_lookup_lru_defines.svh"

module bclru_chk
  import bclru_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic          out_hit;
  logic          out_evicted;
  logic [63:0]   out_victim;
  logic [31:0]   out_count;
  logic          out_bad;
  logic [103:0]  out_rest;
  logic          hit_clean;

  assign out_hit     = m_axis_tdata[6];
  assign out_evicted = m_axis_tdata[7];
  assign out_victim  = m_axis_tdata[71:8];
  assign out_count   = m_axis_tdata[103:72];
  assign out_bad     = m_axis_tdata[104];
  assign out_rest    = m_axis_tdata[103:0];
  assign hit_clean   = !out_evicted && (out_victim == '0) && (out_count != '0);

  `BCLRU_ASSERT_IMPL(a_bad_clean, clk_i, rst_ni, m_axis_tvalid && out_bad, out_rest == '0)
  `BCLRU_ASSERT_IMPL(a_hit_no_evict, clk_i, rst_ni, m_axis_tvalid && out_hit, hit_clean)
  `BCLRU_ASSERT_IMPL(a_claim_count, clk_i, rst_ni, m_axis_tvalid && !out_hit && !out_bad, out_count == 32'd1)
  `BCLRU_ASSERT_IMPL(a_evict_victim, clk_i, rst_ni, m_axis_tvalid && !out_bad, out_evicted == (out_victim != '0))
  `BCLRU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind block_cache_lookup_lru bclru_chk u_bclru_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
